FILE: rtl/core/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and codes of the keyed count table: request and result
// records, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int COUNT_BITS = 31;
  localparam int TAG_BITS   = 16;
  localparam int DELTA_BITS = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] OP_ADJUST = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  typedef struct packed {
    logic signed [DELTA_BITS-1:0] delta;
    logic [TAG_BITS-1:0]          tag_key;
    logic [1:0]                   operation;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic                  present;
    logic [COUNT_BITS-1:0] count_value;
  } res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DONE
  } state_t;

endpackage

FILE: rtl/core/kct_engine.sv
// ----------------------------------------------------------------------------
// kct_engine
// Table memory with its controller: clearing pass after reset, linear scan
// for the key and the lowest free slot, then at most one read-modify-write.
// ----------------------------------------------------------------------------
module kct_engine
  import kct_pkg::*;
#(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int WW = 1 + KEY_BITS + COUNT_BITS;

  logic [WW-1:0] mem [ENTRIES];
  logic [WW-1:0] rd_q;

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic rd_pend, rd_pend_next;
  logic [AW-1:0] rd_addr;

  logic [1:0]               op_q;
  logic [KEY_BITS-1:0]      key_q;
  logic [DELTA_BITS-1:0]    delta_q;
  logic                     found;
  logic [AW-1:0]            fslot;
  logic [COUNT_BITS-1:0]    fcount;
  logic [COUNT_BITS-1:0]    found_count;
  logic                     free_ok;
  logic [AW-1:0]            free_slot;
  res_t                     res_next;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [WW-1:0]         wdata;
  logic [AW-1:0]         raddr;

  logic [KEY_BITS-1:0]   key_in;
  logic                  req_bad;
  logic                  rd_valid;
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_count;

  logic                  neg;
  logic [DELTA_BITS-1:0] mag;
  logic [DELTA_BITS-1:0] sum;
  logic                  sat;
  logic                  drop;
  logic [COUNT_BITS-1:0] diff;

  assign key_in  = KEY_BITS'(32'(req.tag_key));
  assign req_bad = (key_in == '0);

  assign rd_valid = rd_q[WW-1];
  assign rd_key   = rd_q[COUNT_BITS +: KEY_BITS];
  assign rd_count = rd_q[COUNT_BITS-1:0];

  assign found_count = found ? fcount : '0;

  assign neg  = delta_q[DELTA_BITS-1];
  assign mag  = neg ? (~delta_q + DELTA_BITS'(1)) : delta_q;
  assign sum  = {1'b0, fcount} + mag;
  assign sat  = sum > {1'b0, COUNT_MAX};
  assign drop = {1'b0, fcount} <= mag;
  assign diff = fcount - mag[COUNT_BITS-1:0];

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      rd_pend <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= raddr;
    res     <= res_next;
    if (state == S_IDLE && req_valid) begin
      op_q    <= req.operation;
      key_q   <= key_in;
      delta_q <= req.delta;
      found   <= 1'b0;
      free_ok <= 1'b0;
    end else if (state == S_SCAN && rd_pend) begin
      if (rd_valid && rd_key == key_q && !found) begin
        found  <= 1'b1;
        fslot  <= rd_addr;
        fcount <= rd_count;
      end
      if (!rd_valid && !free_ok) begin
        free_ok   <= 1'b1;
        free_slot <= rd_addr;
      end
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    rd_pend_next = 1'b0;
    raddr        = cnt[AW-1:0];
    we           = 1'b0;
    waddr        = fslot;
    wdata        = '0;
    res_next     = res;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt[AW-1:0];
        if (cnt == CW'(ENTRIES - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cnt_next = '0;
          if (req_bad) begin
            res_next   = '{status: ST_INVALID, present: 1'b0, count_value: '0};
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt == CW'(ENTRIES)) begin
          state_next = S_DECIDE;
        end else begin
          rd_pend_next = 1'b1;
          cnt_next     = cnt + CW'(1);
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        res_next   = '{status: ST_OK, present: 1'b0, count_value: '0};
        unique case (op_q)
          OP_ADJUST: begin
            if (delta_q == '0) begin
              res_next = '{status: ST_INVALID, present: found, count_value: found_count};
            end else if (!neg) begin
              if (found) begin
                we    = 1'b1;
                waddr = fslot;
                if (sat) begin
                  wdata    = {1'b1, key_q, COUNT_MAX};
                  res_next = '{status: ST_SATURATED, present: 1'b1, count_value: COUNT_MAX};
                end else begin
                  wdata    = {1'b1, key_q, sum[COUNT_BITS-1:0]};
                  res_next = '{status: ST_OK, present: 1'b1,
                               count_value: sum[COUNT_BITS-1:0]};
                end
              end else if (free_ok) begin
                we       = 1'b1;
                waddr    = free_slot;
                wdata    = {1'b1, key_q, mag[COUNT_BITS-1:0]};
                res_next = '{status: ST_OK, present: 1'b1,
                             count_value: mag[COUNT_BITS-1:0]};
              end else begin
                res_next.status = ST_FULL;
              end
            end else begin
              if (found) begin
                we    = 1'b1;
                waddr = fslot;
                if (drop) begin
                  wdata = '0;
                end else begin
                  wdata    = {1'b1, key_q, diff};
                  res_next = '{status: ST_OK, present: 1'b1, count_value: diff};
                end
              end else begin
                res_next.status = ST_NOT_FOUND;
              end
            end
          end
          OP_REMOVE: begin
            if (found) begin
              we    = 1'b1;
              waddr = fslot;
              wdata = '0;
            end else begin
              res_next.status = ST_NOT_FOUND;
            end
          end
          OP_QUERY: begin
            if (found) begin
              res_next = '{status: ST_OK, present: 1'b1, count_value: fcount};
            end
          end
          default: begin
            res_next = '{status: ST_INVALID, present: found, count_value: found_count};
          end
        endcase
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/keyed_count_table_top.sv
// ----------------------------------------------------------------------------
// keyed_count_table_top
// Table of key-to-count entries; each request adjusts, removes or queries
// one key and returns one result.
//
//   channel   dir  fields (lowest bit first)
//   s_axis    in   operation[1:0], tag_key[17:2], delta[49:18], zero fill
//   m_axis    out  count_value[30:0], present[31], status[34:32], zero fill
//
// A request is scanned with one read per slot through the table memory, the
// last read drains, one decide step follows with any write, and the result
// passes through the engine result register and the output register. The
// engine takes no new request until its result has moved to the output
// register. Key 0 skips the scan and goes straight to the result register.
// After reset a clearing pass over every slot runs with s_axis_tready low.
// A held result stalls the engine; a new request is taken once it is free.
// ----------------------------------------------------------------------------
module keyed_count_table_top
  import kct_pkg::*;
#(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // operation, tag_key, delta, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // count_value, present, status, zero fill
);

  req_t req;
  res_t res;
  res_t out_q;
  logic res_valid;
  logic res_ready;
  logic out_valid;

  assign req.operation = s_axis_tdata[1:0];
  assign req.tag_key   = s_axis_tdata[17:2];
  assign req.delta     = s_axis_tdata[49:18];

  kct_engine #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_q};

endmodule

FILE: tb/tb_keyed_count_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_count_table_top
// Self-checking bench for the keyed count table. A scoreboard keeps its own
// copy of the slot table, predicts count, presence and status for every
// accepted request and checks each result in order. Stimulus runs a short
// directed pass over the special cases, then random requests over key pools
// of several sizes (table fill and overflow included), with random gaps on
// both streams, a gap-free stretch and one long output stall.
// ----------------------------------------------------------------------------
module tb_keyed_count_table_top;
  import kct_pkg::*;

  localparam int          SLOTS      = 64;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int          HOLD_AFTER = 120;
  localparam int          HOLD_LEN   = 400;

  class count_table_scoreboard;
    logic [TAG_BITS-1:0]   slot_key   [SLOTS];
    logic [COUNT_BITS-1:0] slot_count [SLOTS];
    bit                    slot_used  [SLOTS];
    res_t                  expected_q [$];
    int                    errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      errors = 0;
    endfunction

    function int find_key(logic [TAG_BITS-1:0] key);
      foreach (slot_used[i]) if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    function int find_free();
      foreach (slot_used[i]) if (!slot_used[i]) return i;
      return -1;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void note_request(req_t r);
      logic [32:0] mag;
      logic [32:0] sum;
      logic [2:0]  status;
      res_t        res;
      int          idx;
      mag    = r.delta[31] ? 33'h1_0000_0000 - {1'b0, r.delta} : {1'b0, r.delta};
      status = ST_OK;
      if (r.tag_key == '0) begin
        status = ST_INVALID;
      end else begin
        case (r.operation)
          OP_ADJUST: begin
            idx = find_key(r.tag_key);
            if (r.delta == '0) begin
              status = ST_INVALID;
            end else if (!r.delta[31]) begin
              if (idx >= 0) begin
                sum = {2'b0, slot_count[idx]} + mag;
                if (sum > {2'b0, COUNT_MAX}) begin
                  sum    = {2'b0, COUNT_MAX};
                  status = ST_SATURATED;
                end
                slot_count[idx] = sum[COUNT_BITS-1:0];
              end else begin
                idx = find_free();
                if (idx >= 0) begin
                  slot_used[idx]  = 1'b1;
                  slot_key[idx]   = r.tag_key;
                  slot_count[idx] = mag[COUNT_BITS-1:0];
                end else begin
                  status = ST_FULL;
                end
              end
            end else if (idx >= 0) begin
              if ({2'b0, slot_count[idx]} <= mag) slot_used[idx] = 1'b0;
              else slot_count[idx] = slot_count[idx] - mag[COUNT_BITS-1:0];
            end else begin
              status = ST_NOT_FOUND;
            end
          end
          OP_REMOVE: begin
            idx = find_key(r.tag_key);
            if (idx >= 0) slot_used[idx] = 1'b0;
            else status = ST_NOT_FOUND;
          end
          OP_QUERY: ;
          default: status = ST_INVALID;
        endcase
      end
      idx = (r.tag_key == '0) ? -1 : find_key(r.tag_key);
      res.status      = status;
      res.present     = (idx >= 0);
      res.count_value = (idx >= 0) ? slot_count[idx] : '0;
      expected_q.push_back(res);
    endfunction

    task check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing outstanding: %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.count_value !== want.count_value)
        report($sformatf("count_value %0d, want %0d", got.count_value, want.count_value));
      if (got.present !== want.present)
        report($sformatf("present %b, want %b", got.present, want.present));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;   // operation, tag_key, delta, zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // count_value, present, status, zero fill

  bit                    quiet = 1'b0;
  logic [TAG_BITS-1:0]   key_pool [$];
  count_table_scoreboard table_sb = new();

  keyed_count_table_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) table_sb.note_request(s_axis_tdata[49:0]);
      if (m_axis_tvalid && m_axis_tready) table_sb.check_result(m_axis_tdata[34:0]);
    end
  end

  task automatic send_request(logic [1:0] op, logic [TAG_BITS-1:0] key,
                              logic [DELTA_BITS-1:0] delta);
    req_t r;
    int   gap;
    r.operation = op;
    r.tag_key   = key;
    r.delta     = delta;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, r};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic make_pool(int n);
    key_pool.delete();
    repeat (n) key_pool.push_back(TAG_BITS'($urandom_range(1, 16'hFFFF)));
  endtask

  function automatic logic [DELTA_BITS-1:0] draw_delta();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return $urandom_range(1, 60);
    if (pick < 60) return -$urandom_range(1, 60);
    if (pick < 72) return $urandom;
    if (pick < 82) return $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
    if (pick < 88) return -$urandom_range(1000, 32'h7FFF_FFFF);
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h8000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_random(int n);
    int unsigned         pick;
    logic [1:0]          op;
    logic [TAG_BITS-1:0] key;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      op   = (pick < 3) ? OP_UNUSED : (pick < 55) ? OP_ADJUST :
             (pick < 68) ? OP_REMOVE : OP_QUERY;
      pick = $urandom_range(0, 99);
      key  = (pick < 2) ? '0 : (pick < 7) ? TAG_BITS'($urandom) :
             key_pool[$urandom_range(0, key_pool.size() - 1)];
      send_request(op, key, draw_delta());
    end
  endtask

  // hold ready low for a random gap or one long stall, then await one result
  initial begin
    int accepted;
    int gap;
    accepted = 0;
    while (rst) @(posedge clk);
    forever begin
      if (accepted == HOLD_AFTER) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      accepted++;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_QUERY,  16'h0000, 32'd0);
    send_request(OP_ADJUST, 16'h0000, 32'd5);
    send_request(OP_REMOVE, 16'h0000, 32'd0);
    send_request(OP_UNUSED, 16'h1234, 32'd7);
    send_request(OP_QUERY,  16'h1234, 32'd0);
    send_request(OP_REMOVE, 16'h1234, 32'd0);
    send_request(OP_ADJUST, 16'h1234, -5);
    send_request(OP_ADJUST, 16'h1234, 32'd0);
    send_request(OP_ADJUST, 16'hFFFF, 32'h7FFF_FFFF);
    send_request(OP_ADJUST, 16'hFFFF, 32'd1);
    send_request(OP_ADJUST, 16'hFFFF, 32'h7FFF_FFFF);
    send_request(OP_ADJUST, 16'hFFFF, 32'h8000_0000);
    send_request(OP_QUERY,  16'hFFFF, 32'd0);
    send_request(OP_ADJUST, 16'h0001, 32'd10);
    send_request(OP_ADJUST, 16'h0001, -3);
    send_request(OP_ADJUST, 16'h0001, -7);
    send_request(OP_ADJUST, 16'h0001, 32'd100);
    send_request(OP_ADJUST, 16'h0001, -101);
    send_request(OP_ADJUST, 16'h8000, 32'd1);
    send_request(OP_QUERY,  16'h8000, 32'd0);
    send_request(OP_REMOVE, 16'h8000, 32'd0);
    send_request(OP_ADJUST, 16'h0001, 32'h8000_0001);
    send_request(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);

    make_pool(12);
    send_random(180);

    // fill every slot, then push past capacity
    make_pool(80);
    foreach (key_pool[i]) send_request(OP_ADJUST, key_pool[i], $urandom_range(1, 500));
    send_random(140);

    quiet = 1'b1;
    make_pool(20);
    send_random(120);
    quiet = 1'b0;

    make_pool(40);
    send_random(180);

    s_axis_tvalid <= 1'b0;
    while (table_sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (table_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
